@@ src/fdsc_pkg.sv @@
// Package for the float delta symbol coder: field widths, result record,
// configuration register indexes and the float/code mapping helpers.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package fdsc_pkg;

  localparam int unsigned FloatW   = 32;
  localparam int unsigned SymW     = 8;
  localparam int unsigned ResW     = 31;
  localparam int unsigned LenW     = 5;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam logic [SymW-1:0]   EXACT_SYM = 8'd33;
  localparam logic [SymW-1:0]   MAX_SYM   = 8'd65;
  localparam logic [FloatW-1:0] SIGN_BIT  = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_QUANT_SHIFT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECODE_MODE = 2'd1;

  // One result word.
  typedef struct packed {
    logic [SymW-1:0]   symbol_out;
    logic [ResW-1:0]   residual_out;
    logic [LenW-1:0]   residual_length;
    logic [FloatW-1:0] float_out;
    logic              bad_symbol;
  } fdsc_res_t;

  // What a unit hands back besides the result: the new prediction state.
  typedef struct packed {
    logic              code_we;
    logic [FloatW-1:0] code;
  } fdsc_state_t;

  // Order-preserving integer code of a float, reduced by the shift.
  function automatic logic [FloatW-1:0] to_code(input logic [FloatW-1:0] bits,
                                                input logic [ShiftW-1:0] shift);
    logic [FloatW-1:0] m;
    m = bits[FloatW-1] ? ~bits : (bits | SIGN_BIT);
    return m >> shift;
  endfunction

  // Inverse mapping from a code back to float bits.
  function automatic logic [FloatW-1:0] from_code(input logic [FloatW-1:0] code,
                                                  input logic [ShiftW-1:0] shift);
    logic [FloatW-1:0] m;
    m = code << shift;
    return m[FloatW-1] ? (m & ~SIGN_BIT) : ~m;
  endfunction

  // Index of the highest set bit; zero when no bit above bit 0 is set.
  function automatic logic [LenW-1:0] top_bit(input logic [FloatW-1:0] v);
    logic [LenW-1:0] k;
    k = '0;
    for (int i = 1; i < FloatW; i++) begin
      if (v[i]) begin
        k = LenW'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ src/fdsc_enc.sv @@
// Encode datapath: float bits to category symbol and residual bits.
// Depends on fdsc_pkg for widths, the result record and the code mapping.
`default_nettype none

module fdsc_enc (
  input  wire logic [fdsc_pkg::FloatW-1:0] float_bits,
  input  wire logic [fdsc_pkg::FloatW-1:0] pred,
  input  wire logic [fdsc_pkg::ShiftW-1:0] quant_shift,
  output fdsc_pkg::fdsc_res_t              res,
  output fdsc_pkg::fdsc_state_t            state
);

  logic [fdsc_pkg::FloatW-1:0] code;
  logic                        up;
  logic [fdsc_pkg::FloatW-1:0] diff;
  logic [fdsc_pkg::LenW-1:0]   k;
  logic [fdsc_pkg::FloatW-1:0] diff_low;

  assign code     = fdsc_pkg::to_code(float_bits, quant_shift);
  assign up       = code > pred;
  assign diff     = up ? (code - pred) : (pred - code);
  assign k        = fdsc_pkg::top_bit(diff);
  assign diff_low = diff & ~(32'd1 << k);

  always_comb begin
    res           = '0;
    state.code_we = 1'b1;
    state.code    = code;
    if (code == pred) begin
      res.symbol_out = fdsc_pkg::EXACT_SYM;
    end else begin
      res.residual_out    = diff_low[fdsc_pkg::ResW-1:0];
      res.residual_length = k;
      res.symbol_out      = up ? (fdsc_pkg::EXACT_SYM + 8'd1 + {3'd0, k})
                               : (fdsc_pkg::EXACT_SYM - 8'd1 - {3'd0, k});
    end
  end

endmodule

`default_nettype wire

@@ src/fdsc_dec.sv @@
// Decode datapath: category symbol and residual bits back to float bits.
// Depends on fdsc_pkg for widths, the result record and the code mapping.
`default_nettype none

module fdsc_dec (
  input  wire logic [fdsc_pkg::SymW-1:0]   symbol_in,
  input  wire logic [fdsc_pkg::ResW-1:0]   residual_in,
  input  wire logic [fdsc_pkg::FloatW-1:0] pred,
  input  wire logic [fdsc_pkg::ShiftW-1:0] quant_shift,
  output fdsc_pkg::fdsc_res_t              res,
  output fdsc_pkg::fdsc_state_t            state
);

  logic                        bad;
  logic                        up;
  logic [fdsc_pkg::SymW-1:0]   k_wide;
  logic [fdsc_pkg::LenW-1:0]   k;
  logic [fdsc_pkg::FloatW-1:0] lead;
  logic [fdsc_pkg::FloatW-1:0] delta;
  logic [fdsc_pkg::FloatW-1:0] sum;
  logic [fdsc_pkg::FloatW-1:0] code;

  assign bad    = (symbol_in == '0) || (symbol_in > fdsc_pkg::MAX_SYM);
  assign up     = symbol_in > fdsc_pkg::EXACT_SYM;
  assign k_wide = up ? (symbol_in - fdsc_pkg::EXACT_SYM - 8'd1)
                     : (fdsc_pkg::EXACT_SYM - 8'd1 - symbol_in);
  assign k      = k_wide[fdsc_pkg::LenW-1:0];
  assign lead   = 32'd1 << k;
  // Only the k bits under the leading one come from the residual field.
  assign delta  = ({1'b0, residual_in} & (lead - 32'd1)) | lead;

  always_comb begin
    if (symbol_in == fdsc_pkg::EXACT_SYM) begin
      sum = pred;
    end else if (up) begin
      sum = pred + delta;
    end else begin
      sum = pred - delta;
    end
  end

  assign code = sum & (32'hFFFF_FFFF >> quant_shift);

  always_comb begin
    res           = '0;
    state.code_we = !bad;
    state.code    = code;
    if (bad) begin
      res.bad_symbol = 1'b1;
    end else begin
      res.float_out = fdsc_pkg::from_code(code, quant_shift);
    end
  end

endmodule

`default_nettype wire

@@ src/float_delta_symbol_coder.sv @@
// Top level of the float delta symbol coder: ports, input and result
// registers, prediction state and configuration. Uses fdsc_pkg, fdsc_enc, fdsc_dec.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------
//   in_      | sink      | in_tvalid/tready   | tdata: float, symbol, residual
//   out_     | source    | out_tvalid/tready  | tdata: symbol, residual, length, float
//   cfg_     | sink      | cfg_valid/ready    | cfg_index, cfg_data
//
// A word accepted at a clock edge sits in the input register, passes the encode or
// decode datapath from there and is taken into the result register at the edge
// where it moves on. One word per cycle is sustained while the result side does
// not stall, set by the single prediction register that each word updates as
// it leaves the input register. Reset (rst_n low at a clock edge) empties both
// registers, zeroes the prediction and sets lossless encode mode. A stall on the
// result side holds the result, then the input word; in_tready drops only when both
// are full. cfg_ready is always high; writes are expected only while idle.
`default_nettype none

module float_delta_symbol_coder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input words.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] float_bits, [39:32] symbol_in, [70:40] residual_in, [71] zero
  input  wire logic [71:0] in_tdata,
  // [0] first_of_block
  input  wire logic [0:0]  in_tuser,
  // Result words.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] symbol_out, [38:8] residual_out, [43:39] residual_length,
  // [75:44] float_out, [79:76] zero
  output logic [79:0]      out_tdata,
  // [0] bad_symbol
  output logic [0:0]       out_tuser,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [fdsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [fdsc_pkg::CfgDataW-1:0] cfg_data
);

  // Configuration registers.
  logic [fdsc_pkg::ShiftW-1:0] quant_shift_r;
  logic                        decode_mode_r;

  // Input register.
  logic                        in_valid_r;
  logic [fdsc_pkg::FloatW-1:0] float_bits_r;
  logic [fdsc_pkg::SymW-1:0]   symbol_in_r;
  logic [fdsc_pkg::ResW-1:0]   residual_in_r;
  logic                        first_r;

  // Result register and prediction state.
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  fdsc_pkg::fdsc_res_t         out_res_r;
  logic [fdsc_pkg::FloatW-1:0] prev_code_r;

  logic                        advance;
  logic                        in_load;
  logic [fdsc_pkg::FloatW-1:0] pred;
  fdsc_pkg::fdsc_res_t         enc_res;
  fdsc_pkg::fdsc_res_t         dec_res;
  fdsc_pkg::fdsc_state_t       enc_state;
  fdsc_pkg::fdsc_state_t       dec_state;
  fdsc_pkg::fdsc_res_t         res_nxt;
  fdsc_pkg::fdsc_state_t       state_nxt;

  // The input word moves on whenever the result register is free or drains now.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_load   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // A block start predicts from the code of 0.0 at the current shift.
  assign pred = first_r ? (fdsc_pkg::SIGN_BIT >> quant_shift_r) : prev_code_r;

  fdsc_enc u_enc (
    .float_bits  (float_bits_r),
    .pred        (pred),
    .quant_shift (quant_shift_r),
    .res         (enc_res),
    .state       (enc_state)
  );

  fdsc_dec u_dec (
    .symbol_in   (symbol_in_r),
    .residual_in (residual_in_r),
    .pred        (pred),
    .quant_shift (quant_shift_r),
    .res         (dec_res),
    .state       (dec_state)
  );

  assign res_nxt   = decode_mode_r ? dec_res : enc_res;
  assign state_nxt = decode_mode_r ? dec_state : enc_state;

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      prev_code_r   <= '0;
      quant_shift_r <= '0;
      decode_mode_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_load) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance && state_nxt.code_we) begin
        prev_code_r <= state_nxt.code;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fdsc_pkg::CFG_QUANT_SHIFT: quant_shift_r <= cfg_data[fdsc_pkg::ShiftW-1:0];
          fdsc_pkg::CFG_DECODE_MODE: decode_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_load) begin
      float_bits_r  <= in_tdata[31:0];
      symbol_in_r   <= in_tdata[39:32];
      residual_in_r <= in_tdata[70:40];
      first_r       <= in_tuser[0];
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.float_out, out_res_r.residual_length,
                       out_res_r.residual_out, out_res_r.symbol_out};
  assign out_tuser  = out_res_r.bad_symbol;

  // A flagged decode word carries no symbol and no float bits.
  a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.bad_symbol |->
      out_res_r.float_out == '0 && out_res_r.symbol_out == '0)
    else $error("bad symbol result carries data");

  // Every encoded symbol lies in 1..65 and leaves float bits clear.
  a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.symbol_out != '0 |->
      out_res_r.symbol_out <= fdsc_pkg::MAX_SYM && out_res_r.float_out == '0)
    else $error("encoded symbol out of range");

  // Residual bits never reach the leading-one position.
  a_residual_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ({1'b0, out_res_r.residual_out} >> out_res_r.residual_length) == '0)
    else $error("residual wider than its length");

  // A stalled input word is neither lost nor overwritten.
  a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(float_bits_r) &&
      $stable(symbol_in_r))
    else $error("stalled input word changed");

  // The prediction changes only when a word leaves the input register.
  a_pred_update: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(prev_code_r))
    else $error("prediction changed without a word");

endmodule

`default_nettype wire

@@ bench/float_delta_symbol_coder_tb.sv @@
// Self-checking bench for float_delta_symbol_coder: encode and decode words are
// streamed in under random idling and every result word is checked field by field.
// Depends on fdsc_pkg and the float_delta_symbol_coder RTL only.
`timescale 1ns / 100ps

module float_delta_symbol_coder_tb;

  import fdsc_pkg::*;

  // Generous watchdog: about 850 words with random gaps in front of them and
  // stalls on the result side fit well within this limit.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;

  // One input word as the block sees it.
  typedef struct packed {
    logic [FloatW-1:0] float_bits;
    logic [SymW-1:0]   symbol;
    logic [ResW-1:0]   residual;
    logic              first;
  } coder_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  wire               in_tready;
  logic [71:0]       in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  wire               out_tvalid;
  logic              out_tready = 1'b0;
  wire [79:0]        out_tdata;
  wire [0:0]         out_tuser;
  logic              cfg_valid = 1'b0;
  wire               cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of the block's registers and prediction state.
  logic [ShiftW-1:0] drop_bits = '0;
  logic              decoding = 1'b0;
  logic [FloatW-1:0] last_code = '0;

  // Result words still owed by the block, oldest first.
  fdsc_res_t coder_results_due[$];

  // When set, neither side idles or stalls.
  bit steady = 1'b0;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  float_delta_symbol_coder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Order-preserving integer of a float: negatives are inverted, the rest get
  // the sign bit set, so that integer order follows float order.
  function automatic logic [FloatW-1:0] ordered_code(input logic [FloatW-1:0] bits);
    logic [FloatW-1:0] m;
    m = bits[FloatW-1] ? ~bits : {1'b1, bits[FloatW-2:0]};
    return m >> drop_bits;
  endfunction

  function automatic logic [FloatW-1:0] float_of_code(input logic [FloatW-1:0] code);
    logic [FloatW-1:0] m;
    m = code << drop_bits;
    return m[FloatW-1] ? {1'b0, m[FloatW-2:0]} : ~m;
  endfunction

  // Highest set bit above bit 0; zero when only bit 0 or nothing is set.
  function automatic int unsigned msb_index(input logic [FloatW-1:0] v);
    int unsigned k;
    k = 0;
    for (int i = 1; i < FloatW; i++) begin
      if (v[i]) begin
        k = i;
      end
    end
    return k;
  endfunction

  // Works out the result word of one accepted input word and advances the
  // prediction state the same way the block does.
  function automatic fdsc_res_t code_next_word(input coder_word_t w);
    fdsc_res_t r;
    logic [FloatW-1:0] pred;
    logic [FloatW-1:0] code;
    logic [FloatW-1:0] diff;
    logic [FloatW-1:0] low_mask;
    int unsigned k;
    r = '0;
    pred = w.first ? ordered_code('0) : last_code;
    if (!decoding) begin
      code = ordered_code(w.float_bits);
      if (code == pred) begin
        r.symbol_out = EXACT_SYM;
      end else begin
        diff = (code > pred) ? code - pred : pred - code;
        k = msb_index(diff);
        r.residual_out    = ResW'(diff - (32'd1 << k));
        r.residual_length = LenW'(k);
        r.symbol_out = (code > pred) ? SymW'(EXACT_SYM + k + 1) : SymW'(EXACT_SYM - k - 1);
      end
      last_code = code;
    end else if (w.symbol == '0 || w.symbol > MAX_SYM) begin
      // Symbols outside the category range are flagged and leave the state alone.
      r.bad_symbol = 1'b1;
    end else begin
      if (w.symbol == EXACT_SYM) begin
        code = pred;
      end else begin
        k = (w.symbol > EXACT_SYM) ? w.symbol - EXACT_SYM - 1 : EXACT_SYM - w.symbol - 1;
        low_mask = (32'd1 << k) - 32'd1;
        // Residual bits above the length the symbol implies are ignored.
        diff = ({1'b0, w.residual} & low_mask) + (32'd1 << k);
        code = (w.symbol > EXACT_SYM) ? pred + diff : pred - diff;
      end
      // The sum wraps; only the bits that survive the shift are kept.
      code = code & (32'hFFFF_FFFF >> drop_bits);
      r.float_out = float_of_code(code);
      last_code = code;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Sends one word, with a random gap in front of it unless the bench is in a
  // steady stretch. The predictor runs at the edge where the word is taken.
  // in_tvalid is left high so that back-to-back words need no second update
  // within one time step.
  task automatic send_word(input coder_word_t w, output fdsc_res_t due);
    if (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, w.residual, w.symbol, w.float_bits};
    in_tuser  <= w.first;
    do @(posedge clk); while (!in_tready);
    due = code_next_word(w);
    coder_results_due.push_back(due);
  endtask

  // Drops in_tvalid and waits until every owed result has come back, then idles
  // on to cover the two-stage pipeline.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (coder_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_QUANT_SHIFT: drop_bits = val;
      CFG_DECODE_MODE: decoding = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic dec, input logic [ShiftW-1:0] shift);
    write_reg(CFG_QUANT_SHIFT, shift);
    write_reg(CFG_DECODE_MODE, CfgDataW'(dec));
  endtask

  // Builds a word from its fields; callers fill the fields not used in the current mode with random values.
  function automatic coder_word_t make_word(input logic [FloatW-1:0] f,
                                            input logic [SymW-1:0] s,
                                            input logic [ResW-1:0] r,
                                            input logic first);
    coder_word_t w;
    w.float_bits = f;
    w.symbol     = s;
    w.residual   = r;
    w.first      = first;
    return w;
  endfunction

  function automatic logic [FloatW-1:0] special_float();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000;
      5: return 32'hFFFF_FFFF;
      6: return 32'h7FFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("[%0t] mismatch in %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      note_mismatch(what, want, got);
    end
  endtask

  task automatic check_result();
    fdsc_res_t want;
    if (coder_results_due.size() == 0) begin
      note_mismatch("result word with nothing owed", '0, out_tdata[31:0]);
      return;
    end
    want = coder_results_due.pop_front();
    compare_field("symbol_out", want.symbol_out, out_tdata[7:0]);
    compare_field("residual_out", want.residual_out, out_tdata[38:8]);
    compare_field("residual_length", want.residual_length, out_tdata[43:39]);
    compare_field("float_out", want.float_out, out_tdata[75:44]);
    compare_field("tdata padding", '0, out_tdata[79:76]);
    compare_field("bad_symbol", want.bad_symbol, out_tuser[0]);
  endtask

  // Result side: a word is taken at each edge where tvalid and tready are both
  // high. tready is redrawn every cycle; it stays high in steady stretches.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result();
    end
    out_tready <= rst_n && (steady || $urandom_range(99) >= 38);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Runs straight after reset so that the first word meets the cleared
  // prediction register without a block start.
  task automatic test_directed_encode();
    fdsc_res_t due;
    logic [FloatW-1:0] floats[12];
    logic firsts[12];
    floats = '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
               32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F80_0001, 32'h3F80_0001};
    firsts = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    for (int i = 0; i < 12; i++) begin
      send_word(make_word(floats[i], SymW'($urandom), ResW'($urandom), firsts[i]), due);
    end
  endtask

  // Bad symbols at both ends, the widest categories both ways, the narrowest
  // ones, residuals wider than their category, and wrapping sums.
  task automatic test_directed_decode();
    fdsc_res_t due;
    logic [SymW-1:0] syms[11];
    logic [ResW-1:0] resids[11];
    logic firsts[11];
    syms   = '{8'd33, 8'd0, 8'd66, 8'd255, 8'd65, 8'd65, 8'd1, 8'd34, 8'd32, 8'd40, 8'd33};
    resids = '{31'h0, 31'h7FFF_FFFF, 31'h0, 31'h1234, 31'h7FFF_FFFF, 31'h0,
               31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0, 31'h7FFF_FFFF, 31'h5555_5555};
    firsts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    set_mode(1'b1, '0);
    for (int i = 0; i < 11; i++) begin
      send_word(make_word(FloatW'($urandom), syms[i], resids[i], firsts[i]), due);
    end
  endtask

  // Encode stream: half of its words walk near the previous value, so that every
  // category width shows up, mixed with repeats, special values and noise.
  task automatic test_encode_stream(input logic [ShiftW-1:0] shift, input int unsigned count);
    fdsc_res_t due;
    logic [FloatW-1:0] f;
    logic [FloatW-1:0] prev_float;
    int unsigned pick;
    prev_float = $urandom;
    set_mode(1'b0, shift);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        f = prev_float ^ (FloatW'($urandom) & ((32'd1 << $urandom_range(0, 31)) - 32'd1));
      end else if (pick < 62) begin
        f = prev_float;
      end else if (pick < 72) begin
        f = special_float();
      end else begin
        f = $urandom;
      end
      send_word(make_word(f, SymW'($urandom), ResW'($urandom),
                          $urandom_range(15) == 0), due);
      prev_float = f;
    end
  endtask

  // Decode stream: mostly valid categories with random residual bits, with
  // exact predictions and out-of-range symbols mixed in.
  task automatic test_decode_stream(input logic [ShiftW-1:0] shift, input int unsigned count);
    fdsc_res_t due;
    logic [SymW-1:0] s;
    int unsigned pick;
    set_mode(1'b1, shift);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        s = SymW'($urandom_range(1, 65));
      end else if (pick < 90) begin
        s = EXACT_SYM;
      end else if (pick < 93) begin
        s = '0;
      end else begin
        s = SymW'($urandom_range(66, 255));
      end
      send_word(make_word(FloatW'($urandom), s, ResW'($urandom),
                          $urandom_range(15) == 0), due);
    end
  endtask

  // Encodes a walk of floats, then feeds the resulting symbols and residuals
  // back in decode mode with the same shift and block starts.
  task automatic test_round_trip(input logic [ShiftW-1:0] shift, input int unsigned count);
    fdsc_res_t due;
    fdsc_res_t coded[$];
    logic starts[$];
    logic [FloatW-1:0] f;
    logic first;
    f = $urandom;
    set_mode(1'b0, shift);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        f = $urandom;
      end else begin
        f = f ^ (FloatW'($urandom) & ((32'd1 << $urandom_range(0, 24)) - 32'd1));
      end
      first = (i == 0) || ($urandom_range(31) == 0);
      send_word(make_word(f, SymW'($urandom), ResW'($urandom), first), due);
      coded.push_back(due);
      starts.push_back(first);
    end
    set_mode(1'b1, shift);
    for (int i = 0; i < count; i++) begin
      send_word(make_word(FloatW'($urandom), coded[i].symbol_out, coded[i].residual_out,
                          starts[i]), due);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_encode();
    test_directed_decode();

    // A long stretch without idling on either side.
    steady = 1'b1;
    test_encode_stream(5'd0, 150);
    steady = 1'b0;

    test_encode_stream(5'd23, 60);
    test_encode_stream(5'd31, 60);
    test_encode_stream(ShiftW'($urandom_range(1, 22)), 100);
    test_decode_stream(5'd0, 80);
    test_decode_stream(5'd31, 50);
    test_decode_stream(5'd24, 40);
    test_round_trip(5'd7, 80);
    test_decode_stream(ShiftW'($urandom_range(1, 23)), 70);
    test_round_trip(5'd0, 30);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
